### hdl/kpfs_pkg.sv
// ----------------------------------------------------------------------------
// kpfs_pkg
// shared types and constants of the k-th prime factor sieve
// ----------------------------------------------------------------------------
package kpfs_pkg;

   localparam int NUMBER_W  = 14;
   localparam int RANK_W    = 4;
   localparam int FACTOR_W  = 14;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int DEF_MAX_N = 16383;
   localparam int DIV_STEPS = NUMBER_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_OUTER,
      ST_OUTER_CHK,
      ST_INNER,
      ST_INNER_CHK,
      ST_IDLE,
      ST_Q_TEST,
      ST_Q_CHK,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

### hdl/kth_prime_factor_sieve.sv
// ----------------------------------------------------------------------------
// kth_prime_factor_sieve
// smallest-prime-factor table built by a sieve, then k-th prime factor queries
// ----------------------------------------------------------------------------
//  channel  direction  tdata                        tuser
//  req      in         number[13:0], rank[17:14]    -
//  rsp      out        factor[13:0]                 found
//
//  after reset a clearing pass writes every entry 0..MAX_N, then the sieve
//  visits each odd number and each odd multiple of each new odd prime;
//  req_tready stays low
//  a query strips one prime factor per round: one table read and a
//  14-step restoring divider
//  one query at a time; a finished word waits in the rsp register while the
//  next query is taken, and only a second result stalls on rsp_tready
// ----------------------------------------------------------------------------
module kth_prime_factor_sieve #(
   parameter int MAX_N = kpfs_pkg::DEF_MAX_N
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kpfs_pkg::REQ_DATA_W-1:0]   req_tdata,  // number[13:0], rank[17:14]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kpfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // factor[13:0]
   output logic                              rsp_tuser   // found
);
   import kpfs_pkg::*;

   localparam int NW = $clog2(MAX_N + 1);
   localparam int OW = NW + 1;
   localparam int MW = 2 * NW;
   localparam logic [NW-1:0] MAX_IDX = NW'(MAX_N);

   state_type               state_ff, state_in;
   logic [NW-1:0]           clr_ff, clr_in;
   logic [OW-1:0]           outer_ff, outer_in;
   logic [MW-1:0]           mult_ff, mult_in;
   logic [NUMBER_W-1:0]     num_ff, num_in;
   logic [RANK_W-1:0]       rank_ff, rank_in;
   logic [NUMBER_W-1:0]     rem_ff, rem_in;
   logic [NUMBER_W-1:0]     div_p_ff, div_p_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FACTOR_W-1:0]     res_factor_ff, res_factor_in;
   logic                    res_found_ff, res_found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FACTOR_W-1:0]     rsp_factor_ff, rsp_factor_in;
   logic                    rsp_found_ff, rsp_found_in;

   logic                    mem_we;
   logic [NW-1:0]           mem_addr;
   logic [NW-1:0]           mem_wdata;
   logic [NW-1:0]           mem_rd_ff;
   logic [NW-1:0]           spf_mem [0:MAX_N];

   logic [NUMBER_W:0]       rem_sh;
   logic                    div_ge;

   // spf table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         spf_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= spf_mem[mem_addr];
   end

   // restoring divider step
   assign rem_sh = {rem_ff, num_ff[NUMBER_W-1]};
   assign div_ge = rem_sh >= {1'b0, div_p_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      outer_ff      <= outer_in;
      mult_ff       <= mult_in;
      num_ff        <= num_in;
      rank_ff       <= rank_in;
      rem_ff        <= rem_in;
      div_p_ff      <= div_p_in;
      cnt_ff        <= cnt_in;
      res_factor_ff <= res_factor_in;
      res_found_ff  <= res_found_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_found_ff  <= rsp_found_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      outer_in      = outer_ff;
      mult_in       = mult_ff;
      num_in        = num_ff;
      rank_in       = rank_ff;
      rem_in        = rem_ff;
      div_p_in      = div_p_ff;
      cnt_in        = cnt_ff;
      res_factor_in = res_factor_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_factor_in = rsp_factor_ff;
      rsp_found_in  = rsp_found_ff;
      mem_we        = 1'b0;
      mem_addr      = clr_ff;
      mem_wdata     = '0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = (clr_ff >= NW'(2) && !clr_ff[0]) ? NW'(2) : '0;
            clr_in    = clr_ff + NW'(1);
            if (clr_ff == MAX_IDX) begin
               outer_in = OW'(3);
               state_in = ST_OUTER;
            end
         end
         ST_OUTER: begin
            mem_addr = outer_ff[NW-1:0];
            if (outer_ff > OW'(MAX_N)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_OUTER_CHK;
            end
         end
         ST_OUTER_CHK: begin
            mem_addr = outer_ff[NW-1:0];
            if (mem_rd_ff != '0) begin
               outer_in = outer_ff + OW'(2);
               state_in = ST_OUTER;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = outer_ff[NW-1:0];
               mult_in   = {{NW{1'b0}}, outer_ff[NW-1:0]} * {{NW{1'b0}}, outer_ff[NW-1:0]};
               state_in  = ST_INNER;
            end
         end
         ST_INNER: begin
            mem_addr = mult_ff[NW-1:0];
            if (mult_ff > MW'(MAX_N)) begin
               outer_in = outer_ff + OW'(2);
               state_in = ST_OUTER;
            end else begin
               state_in = ST_INNER_CHK;
            end
         end
         ST_INNER_CHK: begin
            mem_addr  = mult_ff[NW-1:0];
            mem_wdata = outer_ff[NW-1:0];
            mem_we    = (mem_rd_ff == '0);
            mult_in   = mult_ff + MW'({outer_ff, 1'b0});
            state_in  = ST_INNER;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               num_in        = req_tdata[NUMBER_W-1:0];
               rank_in       = req_tdata[NUMBER_W+RANK_W-1:NUMBER_W];
               res_factor_in = '0;
               res_found_in  = 1'b0;
               if (req_tdata[NUMBER_W+RANK_W-1:NUMBER_W] == '0 ||
                   32'(req_tdata[NUMBER_W-1:0]) > MAX_N) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_Q_TEST;
               end
            end
         end
         ST_Q_TEST: begin
            mem_addr = NW'(num_ff);
            if (num_ff <= NUMBER_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_Q_CHK;
            end
         end
         ST_Q_CHK: begin
            if (mem_rd_ff < NW'(2)) begin
               state_in = ST_FINISH;
            end else if (rank_ff == RANK_W'(1)) begin
               res_factor_in = FACTOR_W'(mem_rd_ff);
               res_found_in  = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               rank_in  = rank_ff - RANK_W'(1);
               rem_in   = '0;
               div_p_in = NUMBER_W'(mem_rd_ff);
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? NUMBER_W'(rem_sh - {1'b0, div_p_ff}) : rem_sh[NUMBER_W-1:0];
            num_in = {num_ff[NUMBER_W-2:0], div_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_Q_TEST;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_factor_in = res_factor_ff;
               rsp_found_in  = res_found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FACTOR_W){1'b0}}, rsp_factor_ff};
   assign rsp_tuser  = rsp_found_ff;

`ifndef SYNTHESIS
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("result without a factor carries a nonzero value");

   a_found_prime_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_factor_ff >= FACTOR_W'(2))
      else $error("reported factor below two");

   a_div_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_p_ff >= NUMBER_W'(2))
      else $error("divider running with a divisor below two");

   a_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && state_ff == ST_FINISH |=> state_ff == ST_FINISH)
      else $error("pending result left while output word not taken");
`endif

endmodule
